[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked at every rising edge, disabled while reset is asserted.
`define RRQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RRQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/rrq_pkg.sv]
// ---------------------------------------------------------------------------
// rrq_pkg
// Shared types and codes of the retransmit ring queue.
// ---------------------------------------------------------------------------
`default_nettype none

package rrq_pkg;

  localparam int SEQ_W     = 16;
  localparam int DATA_W    = 32;
  localparam int OUT_CNT_W = 7;
  localparam int PAY_EXT_W = 48;

  // Command codes of an input item.
  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_ACK    = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // One input item.
  typedef struct packed {
    logic [1:0]        command;
    logic [SEQ_W-1:0]  seq_number;
    logic [DATA_W-1:0] payload_word;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]           status;
    logic [DATA_W-1:0]    found_payload;
    logic [OUT_CNT_W-1:0] released_count;
    logic [OUT_CNT_W-1:0] occupancy;
    logic [OUT_CNT_W-1:0] window_limit;
  } result_t;

endpackage

`default_nettype wire

[rtl/rrq_in_if.sv]
// ---------------------------------------------------------------------------
// rrq_in_if
// Input channel: command items with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic [rrq_pkg::SEQ_W-1:0]  seq_number;
  logic [rrq_pkg::DATA_W-1:0] payload_word;

  modport source (output valid, output command, output seq_number,
                  output payload_word, input ready);
  modport sink   (input valid, input command, input seq_number,
                  input payload_word, output ready);
endinterface

`default_nettype wire

[rtl/rrq_out_if.sv]
// ---------------------------------------------------------------------------
// rrq_out_if
// Result channel: one result item per command, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface rrq_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [rrq_pkg::DATA_W-1:0]    found_payload;
  logic [rrq_pkg::OUT_CNT_W-1:0] released_count;
  logic [rrq_pkg::OUT_CNT_W-1:0] occupancy;
  logic [rrq_pkg::OUT_CNT_W-1:0] window_limit;

  modport source (output valid, output status, output found_payload,
                  output released_count, output occupancy,
                  output window_limit, input ready);
  modport sink   (input valid, input status, input found_payload,
                  input released_count, input occupancy,
                  input window_limit, output ready);
endinterface

`default_nettype wire

[rtl/retransmit_ring_queue.sv]
// ---------------------------------------------------------------------------
// retransmit_ring_queue
// Sender-side retransmission ring: push, cumulative ack release and lookup
// by sequence number over packets kept in a single-port-read memory.
// ---------------------------------------------------------------------------
//
//   Channel   Dir  Handshake     Contents
//   in_chan   in   valid/ready   command, seq_number, payload_word
//   out_chan  out  valid/ready   status, found_payload, released_count,
//                                occupancy, window_limit
//
// Push, the unused command and an ack or lookup on an empty queue go from
// accept straight to the result state. An ack examines entries from the head
// until one is not released or the queue empties; a lookup examines entries
// from the head until a match, bounded by the occupancy. The walk is set by
// the store's single read port, one entry per cycle. One item is in work at
// a time; a new item is accepted while the previous result waits in the
// output register. Reset is synchronous; the store needs no clearing pass,
// since only entries between head and tail are read.
`default_nettype none

`include "assert_macros.svh"

module retransmit_ring_queue #(
  parameter int CAPACITY       = 64,
  parameter int INITIAL_WINDOW = 1,
  parameter int PAYLOAD_WIDTH  = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rrq_in_if.sink    in_chan,
  rrq_out_if.source out_chan
);

  localparam int IDX_W = $clog2(CAPACITY);

  rrq_pkg::item_t   in_item;
  rrq_pkg::result_t res;
  rrq_pkg::result_t out_r;
  logic             out_valid_r;
  logic             in_ready;
  logic             res_valid;
  logic             res_ready;

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [rrq_pkg::SEQ_W-1:0] wr_seq;
  logic [PAYLOAD_WIDTH-1:0]  wr_pay;
  logic [IDX_W-1:0]          rd_addr;
  logic [rrq_pkg::SEQ_W-1:0] rd_seq;
  logic [PAYLOAD_WIDTH-1:0]  rd_pay;

  // Input item unpacked from the channel.
  assign in_item.command      = in_chan.command;
  assign in_item.seq_number   = in_chan.seq_number;
  assign in_item.payload_word = in_chan.payload_word;
  assign in_chan.ready        = in_ready;

  rrq_ctrl #(
    .CAPACITY       (CAPACITY),
    .INITIAL_WINDOW (INITIAL_WINDOW),
    .PAYLOAD_WIDTH  (PAYLOAD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_seq    (wr_seq),
    .wr_pay    (wr_pay),
    .rd_addr   (rd_addr),
    .rd_seq    (rd_seq),
    .rd_pay    (rd_pay)
  );

  rrq_store #(
    .DEPTH (CAPACITY),
    .PAY_W (PAYLOAD_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_seq  (wr_seq),
    .wr_pay  (wr_pay),
    .rd_addr (rd_addr),
    .rd_seq  (rd_seq),
    .rd_pay  (rd_pay)
  );

  // Output register: loads when empty or when its item is taken this cycle.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_r.status;
  assign out_chan.found_payload  = out_r.found_payload;
  assign out_chan.released_count = out_r.released_count;
  assign out_chan.occupancy      = out_r.occupancy;
  assign out_chan.window_limit   = out_r.window_limit;

  // The controller never offers input readiness while it holds a result.
  `RRQ_ASSERT(a_ready_excl_done, clk, rst_n, in_ready |-> !res_valid, "ready while result pending")
  // An accepted item keeps the input closed on the next cycle.
  `RRQ_ASSERT(a_busy_after_accept, clk, rst_n, (in_chan.valid && in_ready) |=> !in_ready, "input reopened")
  // A result handed to the output register appears on the result channel.
  `RRQ_ASSERT(a_result_loaded, clk, rst_n, (res_valid && res_ready) |=> out_chan.valid, "result lost")

endmodule

`default_nettype wire

[rtl/rrq_store.sv]
// ---------------------------------------------------------------------------
// rrq_store
// Packet store: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rrq_store #(
  parameter int DEPTH = 64,
  parameter int PAY_W = 32
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  wire logic [rrq_pkg::SEQ_W-1:0] wr_seq,
  input  wire logic [PAY_W-1:0]          wr_pay,
  input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic      [rrq_pkg::SEQ_W-1:0] rd_seq,
  output logic      [PAY_W-1:0]          rd_pay
);

  localparam int ENTRY_W = rrq_pkg::SEQ_W + PAY_W;

  logic [ENTRY_W-1:0] mem_r [DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  // Write and registered read; a push to an empty queue reads the entry it
  // writes in the same cycle, but that read data is never used.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= {wr_seq, wr_pay};
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_seq = rd_data_r[ENTRY_W-1:PAY_W];
  assign rd_pay = rd_data_r[PAY_W-1:0];

endmodule

`default_nettype wire

[rtl/rrq_ctrl.sv]
// ---------------------------------------------------------------------------
// rrq_ctrl
// Queue controller: ring pointers, counts and the walk over stored entries.
// ---------------------------------------------------------------------------
`default_nettype none

module rrq_ctrl #(
  parameter int CAPACITY       = 64,
  parameter int INITIAL_WINDOW = 1,
  parameter int PAYLOAD_WIDTH  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input item
  input  wire logic                         in_valid,
  input  wire rrq_pkg::item_t               in_item,
  output logic                              in_ready,
  // Finished result
  output logic                              res_valid,
  output rrq_pkg::result_t                  res,
  input  wire logic                         res_ready,
  // Store ports
  output logic                              wr_en,
  output logic [$clog2(CAPACITY)-1:0]       wr_addr,
  output logic [rrq_pkg::SEQ_W-1:0]         wr_seq,
  output logic [PAYLOAD_WIDTH-1:0]          wr_pay,
  output logic [$clog2(CAPACITY)-1:0]       rd_addr,
  input  wire logic [rrq_pkg::SEQ_W-1:0]    rd_seq,
  input  wire logic [PAYLOAD_WIDTH-1:0]     rd_pay
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int WIN_MAX = (INITIAL_WINDOW > CAPACITY) ? INITIAL_WINDOW : CAPACITY;
  localparam int WIN_W   = $clog2(WIN_MAX + 1);
  localparam int OW      = rrq_pkg::OUT_CNT_W;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [WIN_W-1:0] CAP_WIN  = WIN_W'(CAPACITY);
  localparam logic [WIN_W-1:0] INIT_WIN = WIN_W'(INITIAL_WINDOW);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_LOOK,
    S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [IDX_W-1:0]           head_r, head_nxt;
  logic [IDX_W-1:0]           tail_r, tail_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [WIN_W-1:0]           window_r, window_nxt;

  logic [rrq_pkg::SEQ_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]           scan_r, scan_nxt;
  logic [CNT_W-1:0]           remain_r, remain_nxt;
  logic [CNT_W-1:0]           released_r, released_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [rrq_pkg::DATA_W-1:0] found_r, found_nxt;

  logic [rrq_pkg::PAY_EXT_W-1:0] in_pay_ext;
  logic [rrq_pkg::PAY_EXT_W-1:0] rd_pay_ext;
  logic [CNT_W+OW-1:0]           released_ext;
  logic [CNT_W+OW-1:0]           count_ext;
  logic [WIN_W+OW-1:0]           window_ext;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
  endfunction

  assign in_pay_ext = rrq_pkg::PAY_EXT_W'(in_item.payload_word);
  assign rd_pay_ext = rrq_pkg::PAY_EXT_W'(rd_pay);

  // Next-state logic. The read address always points at the entry whose data
  // is needed in the following cycle, so a walk examines one entry per cycle.
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    window_nxt   = window_r;
    key_nxt      = key_r;
    scan_nxt     = scan_r;
    remain_nxt   = remain_r;
    released_nxt = released_r;
    status_nxt   = status_r;
    found_nxt    = found_r;
    wr_en        = 1'b0;
    wr_addr      = tail_r;
    wr_seq       = in_item.seq_number;
    wr_pay       = in_pay_ext[PAYLOAD_WIDTH-1:0];
    rd_addr      = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt      = in_item.seq_number;
          scan_nxt     = head_r;
          remain_nxt   = count_r;
          released_nxt = '0;
          found_nxt    = '0;
          status_nxt   = rrq_pkg::ST_OK;
          state_nxt    = S_DONE;
          unique case (rrq_pkg::cmd_t'(in_item.command))
            rrq_pkg::CMD_PUSH: begin
              if (count_r == CAP_CNT) begin
                status_nxt = rrq_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                tail_nxt  = next_idx(tail_r);
                count_nxt = count_r + ONE_CNT;
              end
            end
            rrq_pkg::CMD_ACK: begin
              if (count_r == '0) begin
                status_nxt = rrq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_ACK;
              end
            end
            rrq_pkg::CMD_LOOKUP: begin
              if (count_r == '0) begin
                status_nxt = rrq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_LOOK;
              end
            end
            rrq_pkg::CMD_NOP: begin
              status_nxt = rrq_pkg::ST_OK;
            end
          endcase
        end
      end

      // Release from the head while its seqnum is nonzero and below the ack.
      S_ACK: begin
        rd_addr = next_idx(head_r);
        if ((rd_seq < key_r) && (rd_seq != '0)) begin
          head_nxt     = next_idx(head_r);
          count_nxt    = count_r - ONE_CNT;
          released_nxt = released_r + ONE_CNT;
          if ((window_r > WIN_W'(count_nxt)) && (window_r < CAP_WIN)) begin
            window_nxt = window_r + WIN_W'(1);
          end
          if (count_r == ONE_CNT) begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Walk from the head over all held entries until a seqnum matches.
      S_LOOK: begin
        rd_addr = next_idx(scan_r);
        if (rd_seq == key_r) begin
          found_nxt = rd_pay_ext[rrq_pkg::DATA_W-1:0];
          state_nxt = S_DONE;
        end else if (remain_r == ONE_CNT) begin
          status_nxt = rrq_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          scan_nxt   = next_idx(scan_r);
          remain_nxt = remain_r - ONE_CNT;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      window_r <= INIT_WIN;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      window_r <= window_nxt;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    scan_r     <= scan_nxt;
    remain_r   <= remain_nxt;
    released_r <= released_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
  end

  // Result fields, counts reported modulo 128.
  assign released_ext = (CNT_W + OW)'(released_r);
  assign count_ext    = (CNT_W + OW)'(count_r);
  assign window_ext   = (WIN_W + OW)'(window_r);

  assign in_ready           = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.found_payload  = found_r;
  assign res.released_count = released_ext[OW-1:0];
  assign res.occupancy      = count_ext[OW-1:0];
  assign res.window_limit   = window_ext[OW-1:0];

endmodule

`default_nettype wire

[tb/rrq_result_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrq_result_checker
// Watches both channels of the retransmit ring queue. Every accepted command
// item is run through a model of the ring, and its predicted result is
// queued. Every accepted result is compared field by field with the oldest
// prediction. The number of results still awaited and the failure count are
// handed to the testbench top.
// ---------------------------------------------------------------------------
module rrq_result_checker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rrq_in_if           in_chan,
  rrq_out_if          out_chan,
  output int unsigned outstanding,
  output int unsigned mismatches
);
  import rrq_pkg::*;

  localparam int RING_DEPTH   = 64;
  localparam int START_WINDOW = 1;

  // Model copy of the ring and its bookkeeping.
  logic [SEQ_W-1:0]  ring_seq  [RING_DEPTH];
  logic [DATA_W-1:0] ring_data [RING_DEPTH];
  logic [5:0]        head_ptr;
  logic [5:0]        tail_ptr;
  int unsigned       held;
  int unsigned       window;

  result_t     awaited_results[$];
  int unsigned errors = 0;

  // Applies one command to the model ring and returns the result it causes.
  function automatic result_t ring_step(cmd_t op, logic [SEQ_W-1:0] seq,
                                        logic [DATA_W-1:0] data);
    result_t     res;
    int unsigned walk;
    bit          hit;
    logic [5:0]  idx;
    res = '0;
    case (op)
      CMD_PUSH: begin
        if (held == RING_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          ring_seq[tail_ptr]  = seq;
          ring_data[tail_ptr] = data;
          tail_ptr = tail_ptr + 1'b1;
          held++;
        end
      end
      CMD_ACK: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // Release from the head; a zero sequence number stops the release.
          while (held > 0 && ring_seq[head_ptr] != '0 && ring_seq[head_ptr] < seq) begin
            head_ptr = head_ptr + 1'b1;
            held--;
            res.released_count = res.released_count + 1'b1;
            if (window > held && window < RING_DEPTH) window++;
          end
        end
      end
      CMD_LOOKUP: begin
        if (held == 0) begin
          res.status = ST_EMPTY;
        end else begin
          idx = head_ptr;
          hit = 1'b0;
          for (walk = 0; walk < held && !hit; walk++) begin
            if (ring_seq[idx] == seq) begin
              hit = 1'b1;
              res.found_payload = ring_data[idx];
            end
            idx = idx + 1'b1;
          end
          if (!hit) res.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.occupancy    = held[OUT_CNT_W-1:0];
    res.window_limit = window[OUT_CNT_W-1:0];
    return res;
  endfunction

  // Compares one field and counts a failure on a difference.
  task automatic check_field(input string name, input logic [DATA_W-1:0] want_v,
                             input logic [DATA_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      errors++;
    end
  endtask

  // Results are checked before the new item is predicted; a result can never
  // belong to an item accepted at the same edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      head_ptr = '0;
      tail_ptr = '0;
      held     = 0;
      window   = START_WINDOW;
      awaited_results.delete();
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item arrived with no command item outstanding");
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_chan.status);
          check_field("found_payload", want.found_payload, out_chan.found_payload);
          check_field("released_count", want.released_count, out_chan.released_count);
          check_field("occupancy", want.occupancy, out_chan.occupancy);
          check_field("window_limit", want.window_limit, out_chan.window_limit);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        awaited_results.push_back(ring_step(cmd_t'(in_chan.command), in_chan.seq_number,
                                            in_chan.payload_word));
      end
    end
    outstanding <= awaited_results.size();
    mismatches  <= errors;
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the retransmit ring queue. A short directed run
// covers the empty queue and field extremes, then random phases of
// push-heavy, ack-heavy and balanced traffic follow a rising sequence
// counter, with bursty sending and a stalling receiver. Closing items cover
// the zero-sequence cases, and rrq_result_checker beside the block checks.
// ---------------------------------------------------------------------------
module tb;
  import rrq_pkg::*;

  localparam int RANDOM_ITEMS = 1930;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 200;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic        clk;
  logic        rst_n;
  int unsigned outstanding;
  int unsigned mismatches;

  rrq_in_if  in_chan();
  rrq_out_if out_chan();

  retransmit_ring_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rrq_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender state shared by the stimulus tasks.
  int unsigned      burst_left = 0;
  logic [SEQ_W-1:0] next_seq;

  // Offers one item, with a random gap first when a burst has run out.
  task automatic send_item(input cmd_t op, input logic [SEQ_W-1:0] seq,
                           input logic [DATA_W-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid        <= 1'b1;
    in_chan.command      <= op;
    in_chan.seq_number   <= seq;
    in_chan.payload_word <= data;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic hold_until_drained();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // One random item. Pushes follow the sequence counter, skipping zero and
  // the top value, since either would block the head for good.
  task automatic send_random(input mix_t mix);
    int unsigned      pick;
    int unsigned      push_pct;
    int unsigned      ack_pct;
    int unsigned      ack_lo;
    int unsigned      ack_hi;
    cmd_t             op;
    logic [SEQ_W-1:0] seq;
    logic [DATA_W-1:0] data;
    case (mix)
      MIX_FILL:  begin push_pct = 75; ack_pct = 10; ack_lo = 50; ack_hi = 120; end
      MIX_DRAIN: begin push_pct = 20; ack_pct = 50; ack_lo = 0;  ack_hi = 20;  end
      default:   begin push_pct = 40; ack_pct = 30; ack_lo = 0;  ack_hi = 60;  end
    endcase
    pick = $urandom_range(0, 99);
    seq  = $urandom;
    data = $urandom;
    if ($urandom_range(0, 19) == 0) data = $urandom_range(0, 1) ? '1 : '0;
    if (pick < push_pct) begin
      op = CMD_PUSH;
      if ($urandom_range(0, 29) == 0) begin
        seq = $urandom_range(1, 16'hFFFE);
      end else begin
        seq = next_seq;
        next_seq = (next_seq == 16'hFFFE) ? 16'd1 : next_seq + 1'b1;
      end
    end else if (pick < push_pct + ack_pct) begin
      op = CMD_ACK;
      pick = $urandom_range(0, 19);
      if (pick == 0) seq = 16'hFFFF;
      else if (pick > 1) seq = next_seq - 16'($urandom_range(ack_lo, ack_hi));
    end else if (pick < 97) begin
      op = CMD_LOOKUP;
      if ($urandom_range(0, 6) != 0) seq = next_seq - 16'($urandom_range(1, 80));
    end else begin
      op = CMD_NOP;
    end
    send_item(op, seq, data);
  endtask

  // Reset, directed items, random phases, closing items and verdict.
  initial begin
    int unsigned sent;
    int unsigned len;
    mix_t        mix;
    in_chan.valid        <= 1'b0;
    in_chan.command      <= CMD_NOP;
    in_chan.seq_number   <= '0;
    in_chan.payload_word <= '0;
    rst_n                <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue, the unused command and field extremes.
    send_item(CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_ACK, 16'd100, 32'h0);
    send_item(CMD_LOOKUP, 16'd5, 32'h0);
    send_item(CMD_PUSH, 16'd1, 32'h0);
    send_item(CMD_PUSH, 16'hFFFE, 32'hFFFF_FFFF);
    send_item(CMD_PUSH, 16'h8000, 32'hA5A5_A5A5);
    send_item(CMD_LOOKUP, 16'hFFFE, 32'h0);
    send_item(CMD_LOOKUP, 16'h1234, 32'h0);
    send_item(CMD_LOOKUP, 16'd1, 32'hFFFF_FFFF);
    // An ack equal to the head releases nothing; later acks release and grow
    // the window once the queue runs short.
    send_item(CMD_ACK, 16'd1, 32'h0);
    send_item(CMD_ACK, 16'd2, 32'h0);
    send_item(CMD_ACK, 16'hFFFF, 32'h0);
    send_item(CMD_PUSH, 16'd10, 32'h0123_4567);
    send_item(CMD_ACK, 16'd11, 32'h0);
    send_item(CMD_NOP, 16'h0, 32'h0);

    // Random phases; the first one fills the ring until pushes are refused.
    next_seq = 16'hFFFE - 16'($urandom_range(0, 1500));
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix = (sent == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      len = (sent == 0) ? 150 : $urandom_range(60, 250);
      if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
      repeat (len) send_random(mix);
      if (sent == 0 || $urandom_range(0, 2) == 0) hold_until_drained();
      sent += len;
    end

    // A zero sequence number at the head halts release from then on, and a
    // packet numbered at the top can never be acked.
    send_item(CMD_ACK, 16'hFFFF, 32'h0);
    send_item(CMD_PUSH, 16'd7, 32'h7777_7777);
    send_item(CMD_PUSH, 16'h0, $urandom);
    send_item(CMD_PUSH, 16'd9, 32'h9999_9999);
    send_item(CMD_ACK, 16'hFFFF, 32'h0);
    send_item(CMD_LOOKUP, 16'h0, 32'h0);
    send_item(CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_LOOKUP, 16'hFFFF, 32'h0);
    send_item(CMD_ACK, 16'hFFFF, 32'h0);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: always ready, randomly stalled or on a fixed repeating pattern,
  // switching between these modes at random.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(64, 512);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0:       out_chan.ready <= 1'b1;
        1:       out_chan.ready <= ($urandom_range(0, 9) < 7);
        2:       out_chan.ready <= ((stall_tick % 8) >= 3);
        default: out_chan.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Watchdog: too long without any item moving on either channel.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule

[retransmit_ring_queue.f]
+incdir+rtl
rtl/rrq_pkg.sv
rtl/rrq_in_if.sv
rtl/rrq_out_if.sv
rtl/rrq_store.sv
rtl/rrq_ctrl.sv
rtl/retransmit_ring_queue.sv
tb/rrq_result_checker.sv
tb/tb.sv
